// ----- src/bstk_pkg.sv -----
// ----------------------------------------------------------------------------
// bstk_pkg
// Shared sizes, operation codes and status codes for the bounded stack.
// ----------------------------------------------------------------------------
package bstk_pkg;

	// stack depth and derived widths
	localparam int DEPTH = 16;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW    = $clog2(DEPTH + 1);

	// item field widths
	localparam int OP_W   = 3;
	localparam int DATA_W = 32;
	localparam int LOC_W  = 6;
	localparam int ST_W   = 2;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
	localparam logic [OP_W-1:0] OP_POP     = 3'd1;
	localparam logic [OP_W-1:0] OP_DISPLAY = 3'd2;
	localparam logic [OP_W-1:0] OP_PEEP    = 3'd3;
	localparam logic [OP_W-1:0] OP_CHANGE  = 3'd4;

	// status codes
	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [ST_W-1:0] ST_BADLOC   = 2'd3;

endpackage

// ----- src/bstk_ifs.sv -----
// ----------------------------------------------------------------------------
// bstk request and response channels
// Valid/ready channels carrying stack requests and stack results.
// ----------------------------------------------------------------------------
interface bstk_req_if
	import bstk_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic        [OP_W-1:0]   operation;
	logic signed [DATA_W-1:0] value;
	logic        [LOC_W-1:0]  location;

	modport source (output valid, output operation, output value, output location,
		input ready);
	modport sink (input valid, input operation, input value, input location,
		output ready);
endinterface

interface bstk_rsp_if
	import bstk_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic        [ST_W-1:0]   status;
	logic signed [DATA_W-1:0] data;
	logic                     last;

	modport source (output valid, output status, output data, output last,
		input ready);
	modport sink (input valid, input status, input data, input last,
		output ready);
endinterface

// ----- src/bounded_stack_with_indexed_access.sv -----
// ----------------------------------------------------------------------------
// bounded_stack_with_indexed_access
// LIFO stack of signed words with push, pop, peep, change and display.
// ----------------------------------------------------------------------------
// The stack lives in one synchronous RAM of DEPTH words with one write and one
// registered read port, next to a fill counter. A request is taken only while
// the controller is idle; its result goes to an output register, so a new
// request can be taken while the previous result still waits. Push, pop, peep
// and change access the RAM on the accept edge; the result is then loaded into
// the output register from S_RESP. Unknown operation codes give no result and
// leave the controller idle. Display walks the RAM through its single read
// port, one word per cycle while the output is free; on an empty stack it gives
// one ST_EMPTY result. Output back-pressure holds the controller in its state.
// ----------------------------------------------------------------------------
module bounded_stack_with_indexed_access
	import bstk_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	bstk_req_if.sink   req,
	bstk_rsp_if.source rsp
);

	localparam int CW = (FW > LOC_W) ? FW : LOC_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RESP = 3'b010,
		S_DISP = 3'b100
	} state_t;

	state_t state_q;

	logic [FW-1:0] fill_q;
	logic [AW-1:0] idx_q;

	// pending single result
	logic [ST_W-1:0] resp_status_q;
	logic            resp_use_rd_q;

	// stack memory
	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;

	// output register
	logic                     out_valid_q;
	logic        [ST_W-1:0]   out_status_q;
	logic signed [DATA_W-1:0] out_data_q;
	logic                     out_last_q;

	logic                     acc;
	logic                     out_free;
	logic                     full;
	logic                     empty;
	logic                     loc_ok;
	logic                     disp_last;
	logic                     wr_en;
	logic        [AW-1:0]     wr_addr;
	logic signed [DATA_W-1:0] wr_data;
	logic                     rd_en;
	logic        [AW-1:0]     rd_addr;
	logic        [AW-1:0]     loc_addr;
	logic        [AW-1:0]     top_addr;

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.data   = out_data_q;
	assign rsp.last   = out_last_q;

	// occupancy and location checks
	always_comb begin
		full      = (fill_q == FW'(DEPTH));
		empty     = (fill_q == '0);
		loc_ok    = (req.location != '0) && (CW'(req.location) <= CW'(fill_q));
		loc_addr  = AW'(req.location - LOC_W'(1));
		top_addr  = AW'(fill_q - FW'(1));
		disp_last = ((FW'(idx_q) + FW'(1)) == fill_q);
	end

	// memory port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = loc_addr;
		wr_data = req.value;
		rd_en   = 1'b0;
		rd_addr = top_addr;
		if (acc) begin
			case (req.operation)
				OP_PUSH: begin
					wr_en   = !full;
					wr_addr = AW'(fill_q);
				end
				OP_POP: begin
					rd_en   = !empty;
					rd_addr = top_addr;
				end
				OP_DISPLAY: begin
					rd_en   = !empty;
					rd_addr = '0;
				end
				OP_PEEP: begin
					rd_en   = loc_ok;
					rd_addr = loc_addr;
				end
				OP_CHANGE: begin
					wr_en   = loc_ok;
					wr_addr = loc_addr;
				end
				default: ;
			endcase
		end else if (state_q == S_DISP && out_free && !disp_last) begin
			rd_en   = 1'b1;
			rd_addr = idx_q + AW'(1);
		end
	end

	// ram with registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	// controller, fill count and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (req.operation)
							OP_PUSH: begin
								if (!full)
									fill_q <= fill_q + FW'(1);
								state_q <= S_RESP;
							end
							OP_POP: begin
								if (!empty)
									fill_q <= fill_q - FW'(1);
								state_q <= S_RESP;
							end
							OP_DISPLAY: begin
								idx_q   <= '0;
								state_q <= empty ? S_RESP : S_DISP;
							end
							OP_PEEP, OP_CHANGE: state_q <= S_RESP;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RESP: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				S_DISP: begin
					if (out_free) begin
						if (disp_last)
							state_q <= S_IDLE;
						else
							idx_q <= idx_q + AW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// status of the pending single result
	always_ff @(posedge clk) begin
		if (acc) begin
			case (req.operation)
				OP_PUSH: begin
					resp_status_q <= full ? ST_OVERFLOW : ST_OK;
					resp_use_rd_q <= 1'b0;
				end
				OP_POP: begin
					resp_status_q <= empty ? ST_EMPTY : ST_OK;
					resp_use_rd_q <= !empty;
				end
				OP_DISPLAY: begin
					resp_status_q <= ST_EMPTY;
					resp_use_rd_q <= 1'b0;
				end
				OP_PEEP: begin
					resp_status_q <= loc_ok ? ST_OK : ST_BADLOC;
					resp_use_rd_q <= loc_ok;
				end
				OP_CHANGE: begin
					resp_status_q <= loc_ok ? ST_OK : ST_BADLOC;
					resp_use_rd_q <= 1'b0;
				end
				default: begin
					resp_status_q <= ST_OK;
					resp_use_rd_q <= 1'b0;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == S_RESP) || (state_q == S_DISP);
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == S_RESP) begin
				out_status_q <= resp_status_q;
				out_data_q   <= resp_use_rd_q ? rd_data_q : '0;
				out_last_q   <= 1'b1;
			end else if (state_q == S_DISP) begin
				out_status_q <= ST_OK;
				out_data_q   <= rd_data_q;
				out_last_q   <= disp_last;
			end
		end
	end

	// fill count never passes the depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH))
		else $error("fill count above depth");

	// display index stays below the fill count
	a_disp_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DISP) |-> (FW'(idx_q) < fill_q))
		else $error("display index out of range");

	// a push that fits grows the stack by one
	a_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.operation == OP_PUSH && !full) |=> (fill_q == $past(fill_q) + FW'(1)))
		else $error("push did not grow fill count");

	// a pop from a non-empty stack shrinks it by one
	a_pop_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.operation == OP_POP && !empty) |=> (fill_q == $past(fill_q) - FW'(1)))
		else $error("pop did not shrink fill count");

	// the output register is loaded only from a result state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(out_valid_q) && out_valid_q) |->
			($past(state_q) == S_RESP || $past(state_q) == S_DISP))
		else $error("result raised outside a result state");

endmodule
